// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

  // Width of every register, input and result word
  localparam int unsigned REG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DISPATCH,
    S_OUT
  } state_t;

  // Operation running on the shared modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_SQR
  } op_t;

endpackage

// ===== rtl/core/modular_exponentiation_top.sv =====
// Modular exponentiation, right-to-left binary square-and-multiply: each base word
// yields base^power mod modulus, with modulus and power taken from the configuration
// registers (index 0 modulus, reset 2; index 1 power, reset 1; write them only while
// the block is idle) and cut to WIDTH bits. A modulus of 0 or 1 gives 0, a power of 0
// gives 1. All arithmetic runs on one shift-and-add modular multiplier that handles one
// multiplier bit per cycle, and every modular product is followed by a dispatch step.
// An item runs one reduction of the base, then S squarings and M multiplies, where S
// is the bit length of a nonzero power minus one and M the number of one bits in
// power. A modulus below two skips the multiplier and goes straight to output.
// in_ready is high only while the sequencer is idle; a finished result sits in an
// output register, so the next word is taken while that result waits.
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mexp_pkg::REG_W-1:0]          in_base_value,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mexp_pkg::REG_W-1:0]          out_result_value,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mexp_pkg::REG_W-1:0]          cfg_wdata
);

  localparam int unsigned CW = $clog2(WIDTH);

  // (x + y) mod m for x, y < m, no overflow past WIDTH bits
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  // Configuration registers
  logic [mexp_pkg::REG_W-1:0] modulus_r;
  logic [mexp_pkg::REG_W-1:0] power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::REG_W'(2);
      power_r   <= mexp_pkg::REG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mexp_pkg::REG_MODULUS: modulus_r <= cfg_wdata;
        mexp_pkg::REG_POWER:   power_r   <= cfg_wdata;
      endcase
    end
  end

  // Operands cut to WIDTH bits; the user must change registers only while idle, the block does not enforce it
  logic [WIDTH-1:0] m_w;
  assign m_w = WIDTH'(modulus_r);

  // Sequencer and datapath registers
  mexp_pkg::state_t state_r, state_nxt;
  mexp_pkg::op_t    op_r, op_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;     // multiplier accumulator
  logic [WIDTH-1:0] a_r, a_nxt;         // multiplicand
  logic [WIDTH-1:0] mpl_r, mpl_nxt;     // multiplier, MSB first
  logic [WIDTH-1:0] r_r, r_nxt;         // running result
  logic [WIDTH-1:0] b_r, b_nxt;         // running base power
  logic [WIDTH-1:0] e_r, e_nxt;         // remaining exponent bits
  logic             mul_done_r, mul_done_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [mexp_pkg::REG_W-1:0] out_value_r, out_value_nxt;

  // One step of the shared multiplier: double, then add multiplicand on a one bit
  logic [WIDTH-1:0] dbl_w;
  logic [WIDTH-1:0] step_w;
  assign dbl_w  = add_mod(acc_r, acc_r, m_w);
  assign step_w = mpl_r[WIDTH-1] ? add_mod(dbl_w, a_r, m_w) : dbl_w;

  logic in_acc_w;
  assign in_ready  = (state_r == mexp_pkg::S_IDLE);
  assign in_acc_w  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_result_value = out_value_r;

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    mpl_nxt       = mpl_r;
    r_nxt         = r_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    mul_done_nxt  = mul_done_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      mexp_pkg::S_IDLE: begin
        if (in_acc_w) begin
          e_nxt        = WIDTH'(power_r);
          mul_done_nxt = 1'b0;
          if (m_w < WIDTH'(2)) begin
            r_nxt     = '0;
            state_nxt = mexp_pkg::S_OUT;
          end else begin
            // base mod m as the product 1 * base
            r_nxt     = WIDTH'(1);
            acc_nxt   = '0;
            a_nxt     = WIDTH'(1);
            mpl_nxt   = WIDTH'(in_base_value);
            cnt_nxt   = CW'(WIDTH - 1);
            op_nxt    = mexp_pkg::OP_REDUCE;
            state_nxt = mexp_pkg::S_CALC;
          end
        end
      end

      mexp_pkg::S_CALC: begin
        acc_nxt = step_w;
        mpl_nxt = {mpl_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          // write back the finished product
          unique case (op_r)
            mexp_pkg::OP_REDUCE: b_nxt = step_w;
            mexp_pkg::OP_MUL:    r_nxt = step_w;
            mexp_pkg::OP_SQR: begin
              b_nxt = step_w;
              e_nxt = e_r >> 1;
            end
            default: r_nxt = r_r;
          endcase
          state_nxt = mexp_pkg::S_DISPATCH;
        end
      end

      mexp_pkg::S_DISPATCH: begin
        acc_nxt = '0;
        cnt_nxt = CW'(WIDTH - 1);
        priority if (e_r == '0) begin
          state_nxt = mexp_pkg::S_OUT;
        end else if (e_r[0] && !mul_done_r) begin
          a_nxt        = r_r;
          mpl_nxt      = b_r;
          op_nxt       = mexp_pkg::OP_MUL;
          mul_done_nxt = 1'b1;
          state_nxt    = mexp_pkg::S_CALC;
        end else if (e_r[WIDTH-1:1] == '0) begin
          // last exponent bit handled, final squaring not needed
          state_nxt = mexp_pkg::S_OUT;
        end else begin
          a_nxt        = b_r;
          mpl_nxt      = b_r;
          op_nxt       = mexp_pkg::OP_SQR;
          mul_done_nxt = 1'b0;
          state_nxt    = mexp_pkg::S_CALC;
        end
      end

      mexp_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_value_nxt = mexp_pkg::REG_W'(r_r);
          out_valid_nxt = 1'b1;
          state_nxt     = mexp_pkg::S_IDLE;
        end
      end

      default: state_nxt = mexp_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      mul_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mul_done_r  <= mul_done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    a_r         <= a_nxt;
    mpl_r       <= mpl_nxt;
    r_r         <= r_nxt;
    b_r         <= b_nxt;
    e_r         <= e_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTHESIS
  // accumulator stays reduced while the multiplier runs
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mexp_pkg::S_CALC |-> acc_r < m_w)
    else $error("accumulator not reduced by modulus");

  // result and base stay reduced between products
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mexp_pkg::S_DISPATCH |-> (r_r < m_w) && (b_r < m_w))
    else $error("operand not reduced by modulus");

  // a modulus below two goes straight to a zero result
  a_small_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc_w && (m_w < WIDTH'(2)) |=> (state_r == mexp_pkg::S_OUT) && (r_r == '0))
    else $error("small modulus not handled");
`endif

endmodule

// ===== verif/modexp_checker.sv =====
`timescale 1ns / 100ps

// Watches the base, result and register-write ports, predicts every result word
// and compares it against what the block returns, oldest first.
module modexp_checker #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mexp_pkg::REG_W-1:0]     in_base_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [mexp_pkg::REG_W-1:0]     out_result_value,
  input  logic                           cfg_wr_en,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mexp_pkg::REG_W-1:0]     cfg_wdata,
  output int                             error_count,
  output int                             words_in_flight
);

  // operands are cut to WIDTH bits before use
  localparam logic [63:0] OP_MASK = (WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WIDTH) - 64'd1);

  logic [mexp_pkg::REG_W-1:0] modulus_reg;
  logic [mexp_pkg::REG_W-1:0] power_reg;
  logic [mexp_pkg::REG_W-1:0] pending_results[$];
  int                         errs;

  // base^exp mod m, squaring and multiplying from the low exponent bit up
  function automatic logic [mexp_pkg::REG_W-1:0] power_mod(
      input logic [mexp_pkg::REG_W-1:0] base_word,
      input logic [mexp_pkg::REG_W-1:0] mod_word,
      input logic [mexp_pkg::REG_W-1:0] exp_word);
    logic [63:0]  m;
    logic [63:0]  e;
    logic [63:0]  b;
    logic [63:0]  acc;
    logic [127:0] prod;
    m = 64'(mod_word) & OP_MASK;
    e = 64'(exp_word) & OP_MASK;
    b = (64'(base_word) & OP_MASK);
    if (m < 64'd2) begin
      return '0;
    end
    b   = b % m;
    acc = 64'd1;
    while (e != 64'd0) begin
      if (e[0]) begin
        prod = {64'd0, acc} * {64'd0, b};
        acc  = 64'(prod % {64'd0, m});
      end
      e    = e >> 1;
      prod = {64'd0, b} * {64'd0, b};
      b    = 64'(prod % {64'd0, m});
    end
    return acc[mexp_pkg::REG_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [mexp_pkg::REG_W-1:0] want;
    if (!rst_n) begin
      modulus_reg <= mexp_pkg::REG_W'(2);
      power_reg   <= mexp_pkg::REG_W'(1);
      pending_results.delete();
      errs = 0;
      error_count     <= 0;
      words_in_flight <= 0;
    end else begin
      // result side first, so a stray word never pairs with one taken this edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with none expected: result_value %0h", out_result_value);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_result_value !== want) begin
            $error("result_value mismatch: expected %0h, actual %0h", want, out_result_value);
            errs++;
          end
        end
      end
      // prediction uses the register values in force before this edge
      if (in_valid && in_ready) begin
        pending_results.push_back(power_mod(in_base_value, modulus_reg, power_reg));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          mexp_pkg::REG_MODULUS: modulus_reg <= cfg_wdata;
          mexp_pkg::REG_POWER:   power_reg   <= cfg_wdata;
          default: ;
        endcase
      end
      error_count     <= errs;
      words_in_flight <= pending_results.size();
    end
  end

endmodule

// ===== verif/tb_modular_exponentiation_top.sv =====
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

  localparam int unsigned OP_WIDTH   = 32;
  localparam int          IDLE_LIMIT = 40000;
  localparam int          LONG_HOLD  = 3000;
  localparam int          DRAIN_WAIT = 2500;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [mexp_pkg::REG_W-1:0]     in_base_value;
  logic                           out_valid;
  logic                           out_ready;
  logic [mexp_pkg::REG_W-1:0]     out_result_value;
  logic                           cfg_wr_en;
  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mexp_pkg::REG_W-1:0]     cfg_wdata;

  int                         error_count;
  int                         words_in_flight;
  int                         idle_cycles;
  int                         words_sent;
  int                         settings_used;
  logic [mexp_pkg::REG_W-1:0] cur_modulus;
  bit                         calm;
  bit                         long_hold_req;
  bit                         long_hold_done;

  modular_exponentiation_top #(.WIDTH(OP_WIDTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  modexp_checker #(.WIDTH(OP_WIDTH)) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .error_count      (error_count),
    .words_in_flight  (words_in_flight)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 30);
    return $urandom_range(40, 400);
  endfunction

  // exponent with a bit length of 0..8 keeps most words quick
  function automatic logic [mexp_pkg::REG_W-1:0] short_power();
    int len;
    len = $urandom_range(0, 8);
    if (len == 0) return '0;
    return ($urandom() & ((32'd1 << len) - 32'd1)) | (32'd1 << (len - 1));
  endfunction

  function automatic logic [mexp_pkg::REG_W-1:0] pick_modulus(input int phase);
    int r;
    if (phase == 0) return '1;
    if (phase == 1) return mexp_pkg::REG_W'(2);
    r = $urandom_range(0, 9);
    case (r)
      0:       return mexp_pkg::REG_W'(2);
      1:       return '1;
      2:       return mexp_pkg::REG_W'($urandom_range(0, 1));
      3, 4:    return mexp_pkg::REG_W'($urandom_range(3, 255));
      5:       return mexp_pkg::REG_W'($urandom_range(256, 65535));
      default: return $urandom();
    endcase
  endfunction

  // bases: edges, values around the modulus, small and full-range
  function automatic logic [mexp_pkg::REG_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return '0;
      1:       return mexp_pkg::REG_W'(1);
      2:       return '1;
      3:       return cur_modulus - mexp_pkg::REG_W'(1);
      4:       return cur_modulus;
      5:       return cur_modulus + mexp_pkg::REG_W'(1);
      6, 7:    return mexp_pkg::REG_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [mexp_pkg::REG_W-1:0] value);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_base_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_base_value <= $urandom();
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic offer(input logic [mexp_pkg::REG_W-1:0] value);
    send_word(value);
    if (!calm) idle_for(pick_gap());
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mexp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mexp_pkg::REG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  // registers only change once the block has gone quiet
  task automatic apply_setting(input logic [mexp_pkg::REG_W-1:0] mod_word,
                               input logic [mexp_pkg::REG_W-1:0] pow_word);
    wait_all_results();
    write_reg(mexp_pkg::REG_MODULUS, mod_word);
    write_reg(mexp_pkg::REG_POWER, pow_word);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_modulus = mod_word;
    settings_used++;
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall;
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    stall          = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
        stall = 0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) stall = pick_gap();
      end
    end
  end

  // base word stimulus
  initial begin
    int                         n_items;
    bit                         big;
    logic [mexp_pkg::REG_W-1:0] new_mod;
    logic [mexp_pkg::REG_W-1:0] new_pow;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_base_value = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = mexp_pkg::REG_MODULUS;
    cfg_wdata     = '0;
    words_sent    = 0;
    settings_used = 1;
    cur_modulus   = mexp_pkg::REG_W'(2);
    calm          = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: modulus 2, power 1
    offer('0);
    offer(mexp_pkg::REG_W'(1));
    offer('1);
    offer(32'h8000_0000);
    // largest modulus and full-length exponent
    apply_setting('1, '1);
    offer('0);
    offer(mexp_pkg::REG_W'(1));
    offer(32'hFFFF_FFFE);
    offer('1);
    offer(32'h7FFF_FFFF);
    // modulus below two
    apply_setting('0, mexp_pkg::REG_W'(5));
    offer(mexp_pkg::REG_W'(12345));
    offer('1);
    apply_setting(mexp_pkg::REG_W'(1), '0);
    offer('0);
    offer(mexp_pkg::REG_W'(9));
    // zero power
    apply_setting(32'hFFFF_FFFB, '0);
    offer('0);
    offer('1);
    offer(32'hFFFF_FFFB);
    // tiny modulus, square
    apply_setting(mexp_pkg::REG_W'(3), mexp_pkg::REG_W'(2));
    offer('0);
    offer(mexp_pkg::REG_W'(1));
    offer(mexp_pkg::REG_W'(2));
    offer('1);
    // smallest legal modulus with full-length exponent
    apply_setting(mexp_pkg::REG_W'(2), '1);
    offer(mexp_pkg::REG_W'(3));
    offer(mexp_pkg::REG_W'(2));

    // random phases; two use full-width exponents with fewer words
    for (int k = 0; k < 16; k++) begin
      big     = (k == 3) || (k == 11);
      new_mod = pick_modulus(k);
      new_pow = big ? ($urandom() | ((k == 3) ? 32'h8000_0000 : 32'h0)) : short_power();
      apply_setting(new_mod, new_pow);
      calm = (k == 2) || (k == 5);
      // receiver stalls long while the sender keeps offering
      if (k == 5) long_hold_req = 1'b1;
      n_items = big ? 25 : 105;
      for (int i = 0; i < n_items; i++) begin
        if (k == 8 && i == n_items / 2) wait_all_results();
        offer(pick_base());
      end
    end
    calm = 1'b0;

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d base words over %0d register settings", words_sent, settings_used);
    $display("Covered edge bases, moduli 0 to 2^32-1, zero and full-width powers, stalls");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/modular_exponentiation_top.sv
verif/modexp_checker.sv
verif/tb_modular_exponentiation_top.sv
